[hdl/suks_pkg.sv]
// Shared sizes, operation codes and result codes for the sorted key set.
// No dependencies; imported by suks_store and sorted_unique_key_set_core.
package suks_pkg;

	// Number of key slots in the store.
	localparam int CAPACITY = 64;

	// Key width, slot index width and key count width.
	localparam int KEY_W = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Field widths of a result beat.
	localparam int POS_W  = 6;
	localparam int CNTO_W = 7;

	// Operation codes carried by func.
	typedef enum logic [1:0] {
		FN_SEARCH = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	// Result codes carried by status.
	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

endpackage

[hdl/suks_store.sv]
// Key store: one write port and one read port with registered read data.
// Depends on suks_pkg for CAPACITY, KEY_W and IDX_W.
module suks_store
	import suks_pkg::*;
(
	input  logic                    clk,
	input  logic                    we,
	input  logic [IDX_W-1:0]        waddr,
	input  logic signed [KEY_W-1:0] wdata,
	input  logic [IDX_W-1:0]        raddr,
	output logic signed [KEY_W-1:0] rdata
);

	logic signed [KEY_W-1:0] mem [CAPACITY];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data appears the cycle after the address.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/sorted_unique_key_set_core.sv]
// Top level of the sorted key set: request sequencer around the key store.
// Depends on suks_pkg and suks_store.
//
// Usage: the block holds up to CAPACITY distinct signed keys in ascending
// order. A request beat (func, key) is taken at a rising edge where start is
// high and busy is low. Each request yields exactly one result beat (status,
// position, count), shown for one cycle while done is high; the receiver
// cannot stall it and must take it in that cycle.
// Steps, with n keys held and p the ordered position found:
//   clear:  result in the cycle after the request, busy never rises.
//   search: scan upward from slot 0, one read a cycle, until p is found.
//   insert: scan, then shift slots p..n-1 up by one, top first, and write
//           the key at p.
//   remove: scan, then shift slots p+1..n-1 down by one, bottom first.
// The single read port of the store sets the pace: the scan reads one slot
// a cycle and the shift moves one slot a cycle. A new request may be
// given in the cycle that done is high.
// Reset clears the count, so the set is empty; slot contents are not reset
// and their values are only used after they have been written.
module sorted_unique_key_set_core
	import suks_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               func,
	input  logic signed [KEY_W-1:0]  key,
	output logic                     done,
	output logic [1:0]               status,
	output logic [POS_W-1:0]         position,
	output logic [CNTO_W-1:0]        count
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_SHIFT,
		S_PUT
	} state_t;

	state_t                  state_q;
	func_t                   func_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        cur_q;
	logic [CNT_W-1:0]        lb_q;
	logic                    hit_q;
	logic [CNT_W-1:0]        rem_q;
	logic [IDX_W-1:0]        src_q;
	logic [IDX_W-1:0]        dst_q;
	logic                    up_q;
	logic                    pend_q;
	logic                    done_q;
	status_t                 status_q;
	logic [CNT_W-1:0]        pos_q;

	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	logic signed [KEY_W-1:0] mem_wdata;
	logic [IDX_W-1:0]        mem_raddr;
	logic signed [KEY_W-1:0] mem_rdata;
	logic [CNT_W-1:0]        cur_nxt;
	logic [CNT_W-1:0]        cnt_less_lb;

	suks_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cur_nxt     = cur_q + 1'b1;
	assign cnt_less_lb = count_q - lb_q;

	// Store port control: scan reads, shift reads and writes, put writes the key.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = dst_q;
		mem_wdata = mem_rdata;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				mem_raddr = '0;
			end
			S_SCAN: begin
				mem_raddr = cur_nxt[IDX_W-1:0];
			end
			S_SHIFT: begin
				mem_raddr = src_q;
				mem_we    = pend_q;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = lb_q[IDX_W-1:0];
				mem_wdata = key_q;
			end
			default: begin
				mem_raddr = '0;
			end
		endcase
	end

	// Sequencer: scan for the lower bound, decide, shift, write the key.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			done_q   <= 1'b0;
			pend_q   <= 1'b0;
			status_q <= ST_DONE;
			pos_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						key_q  <= key;
						func_q <= func_t'(func);
						if (func_t'(func) == FN_CLEAR) begin
							count_q  <= '0;
							status_q <= ST_DONE;
							pos_q    <= '0;
							done_q   <= 1'b1;
						end else if (count_q == '0) begin
							lb_q    <= '0;
							hit_q   <= 1'b0;
							state_q <= S_DECIDE;
						end else begin
							cur_q   <= '0;
							state_q <= S_SCAN;
						end
					end
				end

				// One slot compared per cycle; stop at the first key not below.
				S_SCAN: begin
					if (mem_rdata >= key_q) begin
						lb_q    <= cur_q;
						hit_q   <= (mem_rdata == key_q);
						state_q <= S_DECIDE;
					end else if (cur_nxt == count_q) begin
						lb_q    <= count_q;
						hit_q   <= 1'b0;
						state_q <= S_DECIDE;
					end else begin
						cur_q <= cur_nxt;
					end
				end

				S_DECIDE: begin
					pend_q <= 1'b0;
					case (func_q)
						FN_SEARCH: begin
							status_q <= hit_q ? ST_DONE : ST_MISS;
							pos_q    <= hit_q ? lb_q : '0;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
						FN_INSERT: begin
							if (hit_q) begin
								status_q <= ST_DUP;
								pos_q    <= lb_q;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (count_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								pos_q    <= '0;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (lb_q == count_q) begin
								state_q <= S_PUT;
							end else begin
								// Move slots lb..count-1 up by one, top first.
								rem_q   <= cnt_less_lb;
								src_q   <= IDX_W'(count_q - 1'b1);
								up_q    <= 1'b1;
								state_q <= S_SHIFT;
							end
						end
						FN_REMOVE: begin
							if (!hit_q) begin
								status_q <= ST_MISS;
								pos_q    <= '0;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (cnt_less_lb == CNT_W'(1)) begin
								count_q  <= count_q - 1'b1;
								status_q <= ST_DONE;
								pos_q    <= lb_q;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								// Move slots lb+1..count-1 down by one, bottom first.
								rem_q   <= cnt_less_lb - 1'b1;
								src_q   <= IDX_W'(lb_q + 1'b1);
								up_q    <= 1'b0;
								state_q <= S_SHIFT;
							end
						end
						default: begin
							status_q <= ST_DONE;
							pos_q    <= '0;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end

				// Read one slot a cycle; its data is written in the following cycle.
				S_SHIFT: begin
					if (rem_q != '0) begin
						dst_q  <= up_q ? src_q + 1'b1 : src_q - 1'b1;
						src_q  <= up_q ? src_q - 1'b1 : src_q + 1'b1;
						rem_q  <= rem_q - 1'b1;
						pend_q <= 1'b1;
					end else if (pend_q) begin
						pend_q <= 1'b0;
						if (up_q) begin
							state_q <= S_PUT;
						end else begin
							count_q  <= count_q - 1'b1;
							status_q <= ST_DONE;
							pos_q    <= lb_q;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end
				end

				S_PUT: begin
					count_q  <= count_q + 1'b1;
					status_q <= ST_DONE;
					pos_q    <= lb_q;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result beat.
	assign busy     = (state_q != S_IDLE);
	assign done     = done_q;
	assign status   = status_q;
	assign position = POS_W'(pos_q);
	assign count    = CNTO_W'(count_q);

endmodule
